// ===== design/lbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Lost block tracker package
// Shared constants, command and reply codes, state encoding and a helper.
// ----------------------------------------------------------------------------
package lbt_pkg;

  localparam int LOST_LIST_DEPTH = 32;
  localparam int MAX_OUT         = 32;

  localparam int SLOT_W  = (LOST_LIST_DEPTH > 1) ? $clog2(LOST_LIST_DEPTH) : 1;
  localparam int CNT_W   = $clog2(LOST_LIST_DEPTH + 1);
  localparam int NUM_W   = 16;
  localparam int LEN_W   = 11;
  localparam int TOT_W   = 6;
  localparam int BYTES_W = 32;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_DATA = 2'd1,
    CMD_RETX = 2'd2,
    CMD_END  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REP_INIT = 2'd0,
    REP_LOST = 2'd1,
    REP_OK   = 2'd2,
    REP_FAIL = 2'd3
  } rep_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_MATCH,
    ST_RESULT,
    ST_SORT,
    ST_EMIT
  } state_e;

  // Saturates the lost count to the width of the reported total.
  function automatic logic [TOT_W-1:0] sat_total(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+TOT_W-1:0] wide;
    wide = (CNT_W+TOT_W)'(cnt);
    if (wide > (CNT_W+TOT_W)'((1 << TOT_W) - 1)) begin
      return {TOT_W{1'b1}};
    end
    return wide[TOT_W-1:0];
  endfunction

endpackage

// ===== design/lbt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module lbt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lost_block_tracker.sv =====
// ----------------------------------------------------------------------------
// Lost block tracker
// Init and single-result end commands pass through ST_RESULT and present a
// registered result once the output register is free. A data block walks
// the slots in ST_GAP, a retransmitted block scans the list in ST_MATCH
// through the one RAM read port, and each lost list entry of an end command
// takes one minimum search pass in ST_SORT. Items are taken one at a time.
// Reset clears control state and all slot valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module lost_block_tracker
  import lbt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [NUM_W-1:0]   block_number_i,
  input  logic [LEN_W-1:0]   block_length_i,
  input  logic               block_check_ok_i,
  input  logic               image_check_ok_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         reply_o,
  output logic [NUM_W-1:0]   lost_block_o,
  output logic [TOT_W-1:0]   lost_total_o,
  output logic               last_o,
  output logic               write_flash_o,
  output logic [BYTES_W-1:0] bytes_received_o
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LOST_LIST_DEPTH);

  state_e                     state_q, state_d;
  cmd_e                       cmd_q, cmd_d;
  logic [NUM_W-1:0]           num_q, num_d;
  logic [LEN_W-1:0]           len_q, len_d;
  logic                       img_q, img_d;

  logic [NUM_W-1:0]           exp_q, exp_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [BYTES_W-1:0]         bytes_q, bytes_d;
  logic                       committed_q, committed_d;
  logic [LOST_LIST_DEPTH-1:0] valid_q, valid_d;
  logic [LOST_LIST_DEPTH-1:0] taken_q, taken_d;

  logic [NUM_W-1:0]           e_q, e_d;
  logic [CNT_W-1:0]           ptr_q, ptr_d;
  logic [CNT_W-1:0]           scan_q, scan_d;
  logic [CNT_W-1:0]           left_q, left_d;
  logic [NUM_W-1:0]           best_q, best_d;
  logic [SLOT_W-1:0]          best_idx_q, best_idx_d;
  logic                       found_q, found_d;

  logic                       out_valid_q;
  rep_e                       out_reply_q, out_reply_d;
  logic [NUM_W-1:0]           out_lost_q, out_lost_d;
  logic [TOT_W-1:0]           out_total_q;
  logic                       out_last_q, out_last_d;
  logic                       out_wf_q, out_wf_d;
  logic [BYTES_W-1:0]         out_bytes_q;
  logic                       out_load;
  logic                       out_free;

  logic                       ram_we;
  logic [SLOT_W-1:0]          ram_waddr;
  logic [SLOT_W-1:0]          ram_raddr;
  logic [NUM_W-1:0]           ram_rdata;
  logic [SLOT_W-1:0]          cmp_idx;
  logic [SLOT_W-1:0]          ptr_idx;

  lbt_ram #(
    .WIDTH(NUM_W),
    .DEPTH(LOST_LIST_DEPTH)
  ) u_list (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(e_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free  = !out_valid_q || out_ready_i;
  assign cmp_idx   = SLOT_W'(scan_q - CNT_W'(1));
  assign ptr_idx   = ptr_q[SLOT_W-1:0];
  assign ram_waddr = ptr_idx;
  assign ram_raddr = (scan_q < DEPTH_C) ? scan_q[SLOT_W-1:0] : '0;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    num_d       = num_q;
    len_d       = len_q;
    img_d       = img_q;
    exp_d       = exp_q;
    cnt_d       = cnt_q;
    bytes_d     = bytes_q;
    committed_d = committed_q;
    valid_d     = valid_q;
    taken_d     = taken_q;
    e_d         = e_q;
    ptr_d       = ptr_q;
    scan_d      = scan_q;
    left_d      = left_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    found_d     = found_q;
    ram_we      = 1'b0;
    out_load    = 1'b0;
    out_reply_d = REP_FAIL;
    out_lost_d  = '0;
    out_last_d  = 1'b1;
    out_wf_d    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_e'(command_i);
          num_d = block_number_i;
          len_d = block_length_i;
          img_d = image_check_ok_i;
          unique case (cmd_e'(command_i))
            CMD_INIT: begin
              valid_d = '0;
              cnt_d   = '0;
              exp_d   = '0;
              state_d = ST_RESULT;
            end
            CMD_DATA: begin
              if (block_check_ok_i) begin
                e_d     = exp_q;
                ptr_d   = '0;
                state_d = ST_GAP;
              end
            end
            CMD_RETX: begin
              if (block_check_ok_i) begin
                scan_d  = '0;
                state_d = ST_MATCH;
              end
            end
            CMD_END: begin
              state_d = ST_RESULT;
            end
          endcase
        end
      end

      ST_GAP: begin
        if (e_q < num_q && cnt_q < DEPTH_C) begin
          if (ptr_q < DEPTH_C && valid_q[ptr_idx]) begin
            ptr_d = ptr_q + CNT_W'(1);
          end else begin
            if (ptr_q < DEPTH_C) begin
              ram_we           = 1'b1;
              valid_d[ptr_idx] = 1'b1;
              ptr_d            = ptr_q + CNT_W'(1);
            end
            cnt_d = cnt_q + CNT_W'(1);
            e_d   = e_q + NUM_W'(1);
          end
        end else begin
          bytes_d = bytes_q + BYTES_W'(len_q);
          exp_d   = num_q + NUM_W'(1);
          state_d = ST_IDLE;
        end
      end

      ST_MATCH: begin
        if (scan_q != '0 && valid_q[cmp_idx] && ram_rdata == num_q) begin
          valid_d[cmp_idx] = 1'b0;
          bytes_d          = bytes_q + BYTES_W'(len_q);
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
        if (scan_q == DEPTH_C) begin
          state_d = ST_IDLE;
        end else begin
          scan_d = scan_q + CNT_W'(1);
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          unique case (cmd_q)
            CMD_INIT: begin
              out_reply_d = REP_INIT;
            end
            CMD_END: begin
              priority if (cnt_q >= DEPTH_C) begin
                out_reply_d = REP_FAIL;
              end else if (cnt_q != '0) begin
                if (|valid_q) begin
                  out_load = 1'b0;
                  taken_d  = '0;
                  scan_d   = '0;
                  found_d  = 1'b0;
                  left_d   = (32'(cnt_q) > MAX_OUT) ? CNT_W'(MAX_OUT) : cnt_q;
                  state_d  = ST_SORT;
                end else begin
                  out_reply_d = REP_FAIL;
                end
              end else if (img_q) begin
                out_reply_d = REP_OK;
                out_wf_d    = !committed_q;
                committed_d = 1'b1;
              end else begin
                out_reply_d = REP_FAIL;
              end
            end
            default: begin
              out_reply_d = REP_FAIL;
            end
          endcase
        end
      end

      ST_SORT: begin
        if (scan_q != '0 && valid_q[cmp_idx] && !taken_q[cmp_idx] &&
            (!found_q || ram_rdata < best_q)) begin
          best_d     = ram_rdata;
          best_idx_d = cmp_idx;
          found_d    = 1'b1;
        end
        if (scan_q == DEPTH_C) begin
          state_d = ST_EMIT;
        end else begin
          scan_d = scan_q + CNT_W'(1);
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_reply_d         = REP_LOST;
          out_lost_d          = best_q;
          out_last_d          = (left_q == CNT_W'(1));
          taken_d[best_idx_q] = 1'b1;
          left_d              = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            scan_d  = '0;
            found_d = 1'b0;
            state_d = ST_SORT;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      exp_q       <= '0;
      cnt_q       <= '0;
      bytes_q     <= '0;
      committed_q <= 1'b0;
      valid_q     <= '0;
      taken_q     <= '0;
      scan_q      <= '0;
      ptr_q       <= '0;
      left_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      cnt_q       <= cnt_d;
      bytes_q     <= bytes_d;
      committed_q <= committed_d;
      valid_q     <= valid_d;
      taken_q     <= taken_d;
      scan_q      <= scan_d;
      ptr_q       <= ptr_d;
      left_q      <= left_d;
      found_q     <= found_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    num_q      <= num_d;
    len_q      <= len_d;
    img_q      <= img_d;
    e_q        <= e_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    if (out_load) begin
      out_reply_q <= out_reply_d;
      out_lost_q  <= out_lost_d;
      out_total_q <= sat_total(cnt_q);
      out_last_q  <= out_last_d;
      out_wf_q    <= out_wf_d;
      out_bytes_q <= bytes_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reply_o          = out_reply_q;
  assign lost_block_o     = out_lost_q;
  assign lost_total_o     = out_total_q;
  assign last_o           = out_last_q;
  assign write_flash_o    = out_wf_q;
  assign bytes_received_o = out_bytes_q;

  // The lost count always matches the number of occupied slots.
  a_count_matches_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(cnt_q))
    else $error("lost count differs from occupied slots");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("lost count above list depth");

  a_taken_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT || state_q == ST_EMIT) |-> ((taken_q & ~valid_q) == '0))
    else $error("emitted slot is not occupied");

  a_flash_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_flash_o) |-> (reply_o == REP_OK && last_o))
    else $error("flash commit without end ok");

endmodule
